// ===== hdl/urgent_front_multi_queue_assert.svh =====
// ----------------------------------------------------------------------------
// urgent_front_multi_queue assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef URGENT_FRONT_MULTI_QUEUE_ASSERT_SVH
`define URGENT_FRONT_MULTI_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UFMQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define UFMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ufmq_pkg.sv =====
// ----------------------------------------------------------------------------
// ufmq_pkg
// sizes, codes and helpers of the urgent-front multi-queue
// ----------------------------------------------------------------------------
package ufmq_pkg;

    localparam int NUM_QUEUES  = 32;
    localparam int QUEUE_DEPTH = 8;
    localparam int ID_BITS     = 16;

    localparam int IDX_BITS = 5;   // queue_index field
    localparam int CAP_BITS = 4;   // capacity_limit register
    localparam int OCC_BITS = 4;   // occupancy field
    localparam int CODE_BITS = 2;

    localparam int Q_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int P_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EA_W  = (NUM_QUEUES * QUEUE_DEPTH > 1) ?
                           $clog2(NUM_QUEUES * QUEUE_DEPTH) : 1;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(8);

    typedef enum logic [0:0] {
        KIND_ADD  = 1'b0,
        KIND_TAKE = 1'b1
    } t_kind;

    typedef enum logic [CODE_BITS-1:0] {
        CODE_ADDED = 2'd0,
        CODE_FULL  = 2'd1,
        CODE_TAKEN = 2'd2,
        CODE_EMPTY = 2'd3
    } t_code;

    // per-queue state word: ring head and fill count
    typedef struct packed {
        logic [P_W-1:0]   head;
        logic [CNT_W-1:0] count;
    } t_meta;

    // stored entry
    typedef struct packed {
        logic               urgent;
        logic [ID_BITS-1:0] id;
    } t_entry;

    // fold a queue_index onto the built queues (constant lookup)
    function automatic logic [Q_W-1:0] queue_of(input logic [IDX_BITS-1:0] idx);
        logic [Q_W-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << IDX_BITS); k++) begin
            if (idx == IDX_BITS'(k)) begin
                r = Q_W'(k % NUM_QUEUES);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/ufmq_if.sv =====
// ----------------------------------------------------------------------------
// ufmq channel interfaces
// valid/ready channels for operations and results
// ----------------------------------------------------------------------------
interface ufmq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [ufmq_pkg::IDX_BITS-1:0] queue_index;
    logic [ufmq_pkg::ID_BITS-1:0]  item_id;
    logic                          urgent;

    modport source (output valid, kind, queue_index, item_id, urgent, input ready);
    modport sink   (input valid, kind, queue_index, item_id, urgent, output ready);
endinterface

interface ufmq_out_if;
    logic                           valid;
    logic                           ready;
    logic [ufmq_pkg::CODE_BITS-1:0] result_code;
    logic [ufmq_pkg::ID_BITS-1:0]   taken_id;
    logic                           taken_urgent;
    logic [ufmq_pkg::OCC_BITS-1:0]  occupancy;

    modport source (output valid, result_code, taken_id, taken_urgent, occupancy,
                    input ready);
    modport sink   (input valid, result_code, taken_id, taken_urgent, occupancy,
                    output ready);
endinterface

// ===== hdl/ufmq_ram.sv =====
// ----------------------------------------------------------------------------
// ufmq_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ufmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/urgent_front_multi_queue.sv =====
// ----------------------------------------------------------------------------
// urgent_front_multi_queue
// bounded multi-queue with urgent push-front, normal push-back and pop-front
// ----------------------------------------------------------------------------
// Each transfer on i_in names a queue and either adds an item (urgent items go
// to the front, others to the back) or takes the front item; exactly one result
// transfer follows on o_out. Operations run one at a time: an add, or a take on
// an empty queue, goes through the read-modify-write of the per-queue state
// memory; a successful take goes on to the read of the entry memory.
// A finished result waits in the output register, so the next operation is
// taken in while the result is still unclaimed; it then stalls only if its
// own result is ready before the previous one left. Each queue is a ring in
// the entry memory with a head pointer and a count; the queue state words
// carry flip-flop valid bits so that reset empties every queue at once, with
// no clearing pass. capacity_limit is written through i_cfg_we/i_cfg_data;
// the user must write it only while no operation is in flight, which the
// block itself does not enforce. Values above the built depth act as the
// depth, zero rejects every add.
// ----------------------------------------------------------------------------
module urgent_front_multi_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ufmq_pkg::CAP_BITS-1:0] i_cfg_data,
    ufmq_in_if.sink                       i_in,
    ufmq_out_if.source                    o_out
);

    localparam int QD = ufmq_pkg::QUEUE_DEPTH;
    localparam int PW = ufmq_pkg::P_W;
    localparam int CW = ufmq_pkg::CNT_W;
    localparam int QW = ufmq_pkg::Q_W;
    localparam int AW = ufmq_pkg::EA_W;
    localparam int IW = ufmq_pkg::ID_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_DATA,
        S_DONE
    } t_state;

    t_state r_state;

    // capacity register
    logic [ufmq_pkg::CAP_BITS-1:0] r_cap;

    // latched operation
    logic          r_kind;
    logic [QW-1:0] r_q;
    logic [IW-1:0] r_id;
    logic          r_urg;
    logic          r_mvld;      // queue state word was ever written

    // one valid bit per queue state word, cleared by reset
    logic [ufmq_pkg::NUM_QUEUES-1:0] r_meta_vld;

    // pending result
    ufmq_pkg::t_code r_res_code;
    logic [IW-1:0]   r_res_id;
    logic            r_res_urg;
    logic [CW-1:0]   r_res_cnt;

    // output register
    logic                           r_o_valid;
    logic [ufmq_pkg::CODE_BITS-1:0] r_o_code;
    logic [IW-1:0]                  r_o_id;
    logic                           r_o_urg;
    logic [ufmq_pkg::OCC_BITS-1:0]  r_o_occ;

    // memory ports
    logic            meta_we;
    logic [QW-1:0]   meta_raddr;
    logic            meta_re;
    ufmq_pkg::t_meta meta_wdata;
    ufmq_pkg::t_meta meta_rdata;
    ufmq_pkg::t_meta meta_cur;

    logic             ent_we;
    logic             ent_re;
    logic [AW-1:0]    ent_addr;
    ufmq_pkg::t_entry ent_wdata;
    ufmq_pkg::t_entry ent_rdata;

    // computed in S_META
    logic          in_fire;
    logic          out_free;
    logic          q_full;
    logic [PW:0]   back_sum;
    logic [PW-1:0] back_slot;
    logic [PW-1:0] front_slot;
    logic [PW:0]   next_sum;
    logic [PW-1:0] next_head;
    logic [PW-1:0] ent_slot;

    ufmq_pkg::t_code n_code;
    logic [CW-1:0]   n_cnt;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_o_valid || o_out.ready;

    assign i_in.ready = (r_state == S_IDLE);

    // queue state as read; never-written words are an empty queue at slot 0
    assign meta_cur = r_mvld ? meta_rdata : '0;

    // full at capacity or at the built depth
    assign q_full = (8'(meta_cur.count) >= 8'(r_cap)) || (meta_cur.count == CW'(QD));

    // ring arithmetic: sums stay below twice the depth
    assign back_sum   = (PW+1)'(meta_cur.head) + (PW+1)'(meta_cur.count);
    assign back_slot  = (back_sum >= (PW+1)'(QD)) ? PW'(back_sum - (PW+1)'(QD))
                                                  : PW'(back_sum);
    assign front_slot = (meta_cur.head == '0) ? PW'(QD - 1) : PW'(meta_cur.head - 1'b1);
    assign next_sum   = (PW+1)'(meta_cur.head) + (PW+1)'(1);
    assign next_head  = (next_sum >= (PW+1)'(QD)) ? PW'(next_sum - (PW+1)'(QD))
                                                  : PW'(next_sum);

    always_comb begin
        meta_we    = 1'b0;
        meta_wdata = meta_cur;
        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ent_slot   = meta_cur.head;
        n_code     = ufmq_pkg::CODE_EMPTY;
        n_cnt      = meta_cur.count;
        if (r_kind == ufmq_pkg::KIND_ADD) begin
            if (q_full) begin
                n_code = ufmq_pkg::CODE_FULL;
            end else begin
                n_code = ufmq_pkg::CODE_ADDED;
                n_cnt  = CW'(meta_cur.count + 1'b1);
                if (r_urg) begin
                    ent_slot        = front_slot;
                    meta_wdata.head = front_slot;
                end else begin
                    ent_slot = back_slot;
                end
                meta_wdata.count = n_cnt;
                meta_we          = (r_state == S_META);
                ent_we           = (r_state == S_META);
            end
        end else begin
            if (meta_cur.count != '0) begin
                n_code           = ufmq_pkg::CODE_TAKEN;
                n_cnt            = CW'(meta_cur.count - 1'b1);
                meta_wdata.head  = next_head;
                meta_wdata.count = n_cnt;
                meta_we          = (r_state == S_META);
                ent_re           = (r_state == S_META);
            end
        end
    end

    assign meta_re    = in_fire;
    assign meta_raddr = ufmq_pkg::queue_of(i_in.queue_index);

    assign ent_addr  = AW'(AW'(r_q) * AW'(QD)) + AW'(ent_slot);
    assign ent_wdata = '{urgent: r_urg, id: r_id};

    ufmq_ram #(
        .WIDTH ($bits(ufmq_pkg::t_meta)),
        .DEPTH (ufmq_pkg::NUM_QUEUES)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_q),
        .i_wdata (meta_wdata),
        .i_re    (meta_re),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    ufmq_ram #(
        .WIDTH ($bits(ufmq_pkg::t_entry)),
        .DEPTH (ufmq_pkg::NUM_QUEUES * QD)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_addr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_addr),
        .o_rdata (ent_rdata)
    );

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= ufmq_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // sequencer with its registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_meta_vld <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            // result offered when it moves out, withdrawn once taken
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_META;
                    end
                end
                S_META: begin
                    if (meta_we) begin
                        r_meta_vld[r_q] <= 1'b1;
                    end
                    // a take with an entry passes through S_DATA to collect its registered read data
                    r_state <= (n_code == ufmq_pkg::CODE_TAKEN) ? S_DATA : S_DONE;
                end
                S_DATA: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= i_in.kind;
            r_q    <= meta_raddr;
            r_id   <= i_in.item_id;
            r_urg  <= i_in.urgent;
            r_mvld <= r_meta_vld[meta_raddr];
        end
        if (r_state == S_META) begin
            r_res_code <= n_code;
            r_res_cnt  <= n_cnt;
            r_res_id   <= '0;
            r_res_urg  <= 1'b0;
        end
        if (r_state == S_DATA) begin
            r_res_id  <= ent_rdata.id;
            r_res_urg <= ent_rdata.urgent;
        end
        if (r_state == S_DONE && out_free) begin
            r_o_code <= r_res_code;
            r_o_id   <= r_res_id;
            r_o_urg  <= r_res_urg;
            r_o_occ  <= ufmq_pkg::OCC_BITS'(r_res_cnt);
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.result_code  = r_o_code;
    assign o_out.taken_id     = r_o_id;
    assign o_out.taken_urgent = r_o_urg;
    assign o_out.occupancy    = r_o_occ;

endmodule

// ===== hdl/ufmq_checker.sv =====
// ----------------------------------------------------------------------------
// ufmq_checker
// port-level checks of the urgent-front multi-queue results
// ----------------------------------------------------------------------------
`include "urgent_front_multi_queue_assert.svh"

module ufmq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           i_ready,
    input logic [ufmq_pkg::CODE_BITS-1:0] i_code,
    input logic [ufmq_pkg::ID_BITS-1:0]   i_id,
    input logic                           i_urg,
    input logic [ufmq_pkg::OCC_BITS-1:0]  i_occ
);

    // a stalled result stays offered
    `UFMQ_ASSERT_NEXT(a_hold, i_valid && !i_ready, i_valid, "result dropped while stalled")

    // only a take returns an item
    `UFMQ_ASSERT_NOW(a_taken_zero, i_valid && (i_code != ufmq_pkg::CODE_TAKEN),
        (i_id == '0) && !i_urg, "taken fields nonzero without a take")

    // an empty take leaves nothing, an add leaves something
    `UFMQ_ASSERT_NOW(a_empty_occ, i_valid && (i_code == ufmq_pkg::CODE_EMPTY),
        i_occ == '0, "empty take with nonzero occupancy")

    `UFMQ_ASSERT_NOW(a_occ_range, i_valid && (i_code == ufmq_pkg::CODE_ADDED),
        (i_occ != '0) && (32'(i_occ) <= ufmq_pkg::QUEUE_DEPTH),
        "occupancy after add out of range")

endmodule

bind urgent_front_multi_queue ufmq_checker u_ufmq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_code  (o_out.result_code),
    .i_id    (o_out.taken_id),
    .i_urg   (o_out.taken_urgent),
    .i_occ   (o_out.occupancy)
);
